FILE: rtl/ipsm_pkg.sv
// Package for the in-place sorted merge block: word type, mode codes and
// sequencer states. It has no dependencies of its own.
`default_nettype none
package ipsm_pkg;

    typedef logic signed [31:0] t_word;

    typedef enum logic [1:0] {
        MODE_LOAD_FIRST  = 2'd0,
        MODE_LOAD_SECOND = 2'd1,
        MODE_RUN         = 2'd2,
        MODE_NONE        = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD_RD,
        S_HEAD_WT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_MRG_RD,
        S_MRG_CMP,
        S_SINK_RD,
        S_SINK_CMP,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/in_place_sorted_merge.sv
// Top level of the in-place sorted merge block: two stores, one shared
// comparator and the sequencer that drives them. Depends on ipsm_pkg.
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+-------------------------------
//   in      | input     | i_in_valid / o_in_stall     | i_mode, i_sample_value
//   out     | output    | o_out_valid / i_out_stall   | o_merged_value, o_last_of_run
//
// A load is written into its store while idle. A run fetches the head of the second store,
// scans the first store backward from its end, walks the first store from the scan stop on,
// sinks each new head of the second store by adjacent swaps (up to n1*(n2-1) swaps), emits
// each element, switches stores and finishes. The single read port of each store and the
// one comparator set its pace. The input is stalled from the run transfer until the
// sequencer is idle again after the last result enters the output register. Reset clears
// only the counts, output valid and sequencer; an output stall holds it in its emit step.
`default_nettype none
module in_place_sorted_merge
    import ipsm_pkg::*;
#(
    parameter int MAX_LEN = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [1:0]          i_mode,
    input  wire logic signed [31:0]  i_sample_value,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic signed [31:0]       o_merged_value,
    output logic                     o_last_of_run
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_LEN);
    localparam logic [CW-1:0] ONE  = CW'(1);

    t_word r_mem_a [MAX_LEN];
    t_word r_mem_b [MAX_LEN];

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_j, n_j;
    logic r_side, n_side;
    t_word r_head, n_head;
    t_word r_cur, n_cur;
    t_word r_rd_a, r_rd_b;
    logic r_out_valid, n_out_valid;
    t_word r_out_data, n_out_data;
    logic r_out_last, n_out_last;

    logic [AW-1:0] rd_addr_a, rd_addr_b, wr_addr_a, wr_addr_b;
    logic we_a, we_b;
    t_word wd_a, wd_b;
    t_word cmp_x, cmp_y;
    logic gt;
    logic in_xfer, out_free;
    logic [CW-1:0] idx_m1, idx_p1, j_p1;
    t_mode mode;

    assign mode     = t_mode'(i_mode);
    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign idx_m1   = r_idx - ONE;
    assign idx_p1   = r_idx + ONE;
    assign j_p1     = r_j + ONE;

    // The one comparator shared by scan, merge and sink steps.
    always_comb begin
        cmp_x = r_rd_a;
        cmp_y = r_head;
        if (r_state == S_SINK_CMP) begin
            cmp_x = r_cur;
            cmp_y = r_rd_b;
        end
    end
    assign gt = cmp_x > cmp_y;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && mode == MODE_RUN) begin
                    if (r_cnt_a == '0 || r_cnt_b == '0) begin
                        n_state = S_EMIT_RD;
                    end else begin
                        n_state = S_HEAD_RD;
                    end
                end
            end
            S_HEAD_RD:  n_state = S_HEAD_WT;
            S_HEAD_WT:  n_state = S_SCAN_RD;
            S_SCAN_RD:  n_state = (r_idx == '0) ? S_MRG_RD : S_SCAN_CMP;
            S_SCAN_CMP: n_state = gt ? S_SCAN_RD : S_MRG_RD;
            S_MRG_RD:   n_state = (r_idx == r_cnt_a) ? S_EMIT_RD : S_MRG_CMP;
            S_MRG_CMP:  n_state = gt ? S_SINK_RD : S_MRG_RD;
            S_SINK_RD:  n_state = (j_p1 == r_cnt_b) ? S_MRG_RD : S_SINK_CMP;
            S_SINK_CMP: n_state = gt ? S_SINK_RD : S_MRG_RD;
            S_EMIT_RD: begin
                if (r_side && r_idx == r_cnt_b) begin
                    n_state = S_IDLE;
                end else if (r_side || r_idx != r_cnt_a) begin
                    n_state = S_EMIT_OUT;
                end
            end
            S_EMIT_OUT: n_state = out_free ? S_EMIT_RD : S_EMIT_OUT;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_idx       = r_idx;
        n_j         = r_j;
        n_side      = r_side;
        n_head      = r_head;
        n_cur       = r_cur;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        rd_addr_a   = r_idx[AW-1:0];
        rd_addr_b   = '0;
        we_a        = 1'b0;
        we_b        = 1'b0;
        wr_addr_a   = r_idx[AW-1:0];
        wr_addr_b   = r_j[AW-1:0];
        wd_a        = r_head;
        wd_b        = r_cur;
        o_in_stall  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                wd_a      = i_sample_value;
                wd_b      = i_sample_value;
                wr_addr_a = r_cnt_a[AW-1:0];
                wr_addr_b = r_cnt_b[AW-1:0];
                n_idx     = '0;
                n_side    = 1'b0;
                if (in_xfer && mode == MODE_LOAD_FIRST && r_cnt_a < FULL) begin
                    we_a    = 1'b1;
                    n_cnt_a = r_cnt_a + ONE;
                end
                if (in_xfer && mode == MODE_LOAD_SECOND && r_cnt_b < FULL) begin
                    we_b    = 1'b1;
                    n_cnt_b = r_cnt_b + ONE;
                end
            end
            S_HEAD_RD: begin
                rd_addr_b = '0;
            end
            S_HEAD_WT: begin
                n_head = r_rd_b;
                n_idx  = r_cnt_a;
            end
            S_SCAN_RD: begin
                rd_addr_a = idx_m1[AW-1:0];
            end
            S_SCAN_CMP: begin
                if (gt) begin
                    n_idx = idx_m1;
                end
            end
            S_MRG_RD: begin
                rd_addr_a = r_idx[AW-1:0];
                n_side    = 1'b0;
                if (r_idx == r_cnt_a) begin
                    n_idx = '0;
                end
            end
            S_MRG_CMP: begin
                if (gt) begin
                    we_a  = 1'b1;
                    n_cur = r_rd_a;
                    n_j   = '0;
                end else begin
                    n_idx = idx_p1;
                end
            end
            S_SINK_RD: begin
                rd_addr_b = j_p1[AW-1:0];
                if (j_p1 == r_cnt_b) begin
                    we_b  = 1'b1;
                    n_idx = idx_p1;
                    if (r_j == '0) begin
                        n_head = r_cur;
                    end
                end
            end
            S_SINK_CMP: begin
                we_b = 1'b1;
                if (gt) begin
                    wd_b = r_rd_b;
                    n_j  = j_p1;
                    if (r_j == '0) begin
                        n_head = r_rd_b;
                    end
                end else begin
                    n_idx = idx_p1;
                    if (r_j == '0) begin
                        n_head = r_cur;
                    end
                end
            end
            S_EMIT_RD: begin
                rd_addr_a = r_idx[AW-1:0];
                rd_addr_b = r_idx[AW-1:0];
                if (r_side && r_idx == r_cnt_b) begin
                    n_cnt_a = '0;
                    n_cnt_b = '0;
                end else if (!r_side && r_idx == r_cnt_a) begin
                    n_side = 1'b1;
                    n_idx  = '0;
                end
            end
            S_EMIT_OUT: begin
                rd_addr_a = r_idx[AW-1:0];
                rd_addr_b = r_idx[AW-1:0];
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_side ? r_rd_b : r_rd_a;
                    n_out_last  = r_side ? (idx_p1 == r_cnt_b)
                                         : (idx_p1 == r_cnt_a && r_cnt_b == '0);
                    n_idx       = idx_p1;
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            r_mem_a[wr_addr_a] <= wd_a;
        end
        r_rd_a <= r_mem_a[rd_addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            r_mem_b[wr_addr_b] <= wd_b;
        end
        r_rd_b <= r_mem_b[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_j        <= n_j;
        r_side     <= n_side;
        r_head     <= n_head;
        r_cur      <= n_cur;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_merged_value = r_out_data;
    assign o_last_of_run  = r_out_last;

    a_merge_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MRG_RD) |-> (r_idx <= r_cnt_a))
        else $error("merge index ran past the first store");

    a_sink_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SINK_CMP) |-> (j_p1 < r_cnt_b))
        else $error("sink step read past the second store");

    a_counts_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_RD && n_state == S_IDLE) |=> (r_cnt_a == '0 && r_cnt_b == '0))
        else $error("counts not cleared at the end of a run");

endmodule
`default_nettype wire

FILE: dv/tb_in_place_sorted_merge.sv
// Self-checking testbench for in_place_sorted_merge: a directed table, then random load/run
// sequences with random idling on both channels, checked against an in-bench merge predictor.
// Depends on ipsm_pkg and the in_place_sorted_merge RTL.
module tb_in_place_sorted_merge;
    import ipsm_pkg::*;

    localparam int STORE_DEPTH  = 32;
    localparam int RANDOM_ITEMS = 90;
    localparam int STUCK_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        t_word value;
        logic  last;
    } merged_t;

    typedef struct packed {
        logic [1:0] mode;
        t_word      value;
        logic       typed;
        t_word      typed_value;
    } row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [1:0] in_mode = MODE_NONE;
    t_word      in_value = '0;
    logic       out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_word      o_merged_value;
    logic       o_last_of_run;

    t_word   first_store [STORE_DEPTH];
    t_word   second_store [STORE_DEPTH];
    int      first_len = 0;
    int      second_len = 0;
    merged_t run_output [$];
    merged_t pending_merged [$];

    int errors = 0;
    int items_sent = 0;
    int runs_sent = 0;
    int results_seen = 0;
    int run_len = 0;
    int longest_run = 0;
    int stuck_cycles = 0;
    int send_calm = 0;
    int recv_calm = 0;

    row_t directed [22] = '{
        '{MODE_RUN,         32'sh00000000, 1'b0, 32'sh0},
        '{MODE_NONE,        32'shFFFFFFFF, 1'b0, 32'sh0},
        '{MODE_LOAD_FIRST,  32'sh7FFFFFFF, 1'b0, 32'sh0},
        '{MODE_RUN,         32'sh00000000, 1'b1, 32'sh7FFFFFFF},
        '{MODE_LOAD_SECOND, 32'sh80000000, 1'b0, 32'sh0},
        '{MODE_RUN,         32'shFFFFFFFF, 1'b1, 32'sh80000000},
        '{MODE_LOAD_FIRST,  32'sh7FFFFFFF, 1'b0, 32'sh0},
        '{MODE_LOAD_SECOND, 32'sh80000000, 1'b0, 32'sh0},
        '{MODE_RUN,         32'sh00000000, 1'b0, 32'sh0},
        '{MODE_LOAD_FIRST,  32'sh00010000, 1'b0, 32'sh0},
        '{MODE_LOAD_FIRST,  32'sh00050000, 1'b0, 32'sh0},
        '{MODE_LOAD_SECOND, 32'sh00020000, 1'b0, 32'sh0},
        '{MODE_LOAD_SECOND, 32'sh00030000, 1'b0, 32'sh0},
        '{MODE_NONE,        32'sh12345678, 1'b0, 32'sh0},
        '{MODE_RUN,         32'sh00000000, 1'b0, 32'sh0},
        '{MODE_LOAD_FIRST,  32'sh00090000, 1'b0, 32'sh0},
        '{MODE_LOAD_FIRST,  32'shFFFF0000, 1'b0, 32'sh0},
        '{MODE_LOAD_SECOND, 32'sh00040000, 1'b0, 32'sh0},
        '{MODE_RUN,         32'sh00000000, 1'b0, 32'sh0},
        '{MODE_LOAD_FIRST,  32'shFFFFFFFF, 1'b0, 32'sh0},
        '{MODE_LOAD_SECOND, 32'shFFFFFFFF, 1'b0, 32'sh0},
        '{MODE_RUN,         32'sh00000000, 1'b0, 32'sh0}
    };

    in_place_sorted_merge dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (in_mode),
        .i_sample_value (in_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_merged_value (o_merged_value),
        .o_last_of_run  (o_last_of_run)
    );

    always #4 clk = ~clk;

    function automatic int draw_gap(ref int calm);
        int gap;
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 13);
            if ($urandom_range(0, 9) == 0) begin
                calm = $urandom_range(5, 20);
            end
        end
        return gap;
    endfunction

    // Applies one transfer to the predicted stores and leaves the values it emits in run_output.
    function automatic void apply_to_stores(input logic [1:0] mode, input t_word value);
        int    start;
        int    k;
        int    j;
        int    total;
        t_word swap;
        run_output.delete();
        case (mode)
            MODE_LOAD_FIRST: begin
                if (first_len < STORE_DEPTH) begin
                    first_store[first_len] = value;
                    first_len++;
                end
            end
            MODE_LOAD_SECOND: begin
                if (second_len < STORE_DEPTH) begin
                    second_store[second_len] = value;
                    second_len++;
                end
            end
            MODE_RUN: begin
                if (first_len != 0 && second_len != 0) begin
                    start = first_len;
                    while (start > 0 && first_store[start - 1] > second_store[0]) begin
                        start--;
                    end
                    for (k = start; k < first_len; k++) begin
                        if (first_store[k] > second_store[0]) begin
                            swap = first_store[k];
                            first_store[k] = second_store[0];
                            second_store[0] = swap;
                            j = 0;
                            while (j + 1 < second_len && second_store[j] > second_store[j + 1]) begin
                                swap = second_store[j];
                                second_store[j] = second_store[j + 1];
                                second_store[j + 1] = swap;
                                j++;
                            end
                        end
                    end
                end
                total = first_len + second_len;
                for (k = 0; k < first_len; k++) begin
                    run_output.push_back('{first_store[k], (k + 1 == total)});
                end
                for (k = 0; k < second_len; k++) begin
                    run_output.push_back('{second_store[k], (first_len + k + 1 == total)});
                end
                first_len = 0;
                second_len = 0;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void make_values(ref t_word vals[$], input int count, input int shape);
        longint cur;
        longint max_step;
        longint step;
        int     i;
        vals.delete();
        if (shape < 6) begin
            cur = longint'(t_word'($urandom));
            for (i = 0; i < count; i++) begin
                vals.push_back(t_word'(cur));
                if (i + 1 < count) begin
                    max_step = (64'sd2147483647 - cur) / (count - 1 - i);
                    step = longint'({$urandom, $urandom} >> 1) % (max_step + 1);
                    if ($urandom_range(0, 3) == 0) begin
                        step = 0;
                    end
                    cur = cur + step;
                end
            end
        end else if (shape < 8) begin
            cur = longint'($urandom_range(0, 8)) - 4;
            for (i = 0; i < count; i++) begin
                vals.push_back(t_word'(cur * 65536));
                cur = cur + $urandom_range(0, 1);
            end
        end else begin
            for (i = 0; i < count; i++) begin
                vals.push_back(t_word'($urandom));
            end
        end
    endfunction

    task automatic send_item(input logic [1:0] mode, input t_word value, input logic typed,
                             input t_word typed_value);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_value <= value;
        do @(posedge clk); while (o_in_stall !== 1'b0);
        items_sent++;
        if (mode == MODE_RUN) begin
            runs_sent++;
        end
        apply_to_stores(mode, value);
        if (typed) begin
            pending_merged.push_back('{typed_value, 1'b1});
        end else begin
            foreach (run_output[i]) begin
                pending_merged.push_back(run_output[i]);
            end
        end
    endtask

    initial begin : receiver
        int gap;
        bit held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            gap = draw_gap(recv_calm);
            if (!held && results_seen >= 20) begin
                held = 1'b1;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (o_out_valid !== 1'b1);
        end
    end

    always @(posedge clk) begin : result_check
        merged_t want;
        if (rst_n && o_out_valid === 1'b1 && !out_stall) begin
            results_seen++;
            run_len++;
            if (o_last_of_run === 1'b1) begin
                if (run_len > longest_run) begin
                    longest_run = run_len;
                end
                run_len = 0;
            end
            if (pending_merged.size() == 0) begin
                $error("merged_value: expected none, got %0d", o_merged_value);
                errors++;
            end else begin
                want = pending_merged.pop_front();
                if (o_merged_value !== want.value) begin
                    $error("merged_value: expected %0d, got %0d", want.value, o_merged_value);
                    errors++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last, o_last_of_run);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin : stimulus
        t_word first_vals [$];
        t_word second_vals [$];
        int    random_items;
        int    seq;
        int    n1;
        int    n2;
        int    shape;
        random_items = 0;
        seq = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[r]) begin
            send_item(directed[r].mode, directed[r].value, directed[r].typed,
                      directed[r].typed_value);
        end

        while (random_items < RANDOM_ITEMS) begin
            seq++;
            if (seq == 2) begin
                // Overfill both stores so the dropped loads and the longest run are exercised.
                n1 = STORE_DEPTH + 2;
                n2 = STORE_DEPTH + 1;
            end else begin
                n1 = ($urandom_range(0, 9) == 0) ? $urandom_range(7, STORE_DEPTH) : $urandom_range(0, 6);
                n2 = ($urandom_range(0, 9) == 0) ? $urandom_range(7, STORE_DEPTH) : $urandom_range(0, 6);
            end
            shape = $urandom_range(0, 9);
            make_values(first_vals, n1, shape);
            make_values(second_vals, n2, shape);
            while (first_vals.size() != 0 || second_vals.size() != 0) begin
                if ($urandom_range(0, 11) == 0) begin
                    send_item(MODE_NONE, t_word'($urandom), 1'b0, '0);
                end
                if (first_vals.size() != 0 && (second_vals.size() == 0 || $urandom_range(0, 1) == 1)) begin
                    send_item(MODE_LOAD_FIRST, first_vals.pop_front(), 1'b0, '0);
                end else begin
                    send_item(MODE_LOAD_SECOND, second_vals.pop_front(), 1'b0, '0);
                end
                random_items++;
            end
            send_item(MODE_RUN, t_word'($urandom), 1'b0, '0);
            random_items++;
        end
        in_valid <= 1'b0;

        while (pending_merged.size() != 0) begin
            @(posedge clk);
        end
        repeat (64) @(posedge clk);

        $display("Sent %0d input transfers including %0d merge runs; checked %0d results,",
                 items_sent, runs_sent, results_seen);
        $display("the longest run emitted %0d values.", longest_run);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
